@@ rtl/pna_pkg.sv @@
// ----------------------------------------------------------------------------
// pna_pkg
// Shared widths, operation and status codes, and register indexes of the
// port number allocator.
// ----------------------------------------------------------------------------
package pna_pkg;

  localparam int PORT_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 17;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE   = 2'd0,
    OP_ALLOC_ONE = 2'd1,
    OP_ALLOC_TWO = 2'd2,
    OP_RELEASE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

endpackage

@@ rtl/pna_divmod.sv @@
// ----------------------------------------------------------------------------
// pna_divmod
// Splits a port number into bitmap word index and bit offset for a constant
// word size by reciprocal multiplication: quotient registered at the start
// edge, then the remainder computed from it and registered.
// ----------------------------------------------------------------------------
module pna_divmod #(
  parameter int DIVISOR = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pna_pkg::PORT_W-1:0]  dividend_i,
  output logic                        done_o,
  output logic [pna_pkg::PORT_W-1:0]  quot_o,
  output logic [$clog2(DIVISOR)-1:0]  rem_o
);
  import pna_pkg::*;

  localparam int RW = $clog2(DIVISOR);
  localparam int SH = PORT_W + RW;
  localparam int MW = 2 * PORT_W + 1;
  // ceil(2^SH / DIVISOR) fits in PORT_W + 1 bits and is exact for every dividend
  localparam logic [PORT_W:0] RECIP = (PORT_W + 1)'(
    ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));
  localparam logic [PORT_W-1:0] DIV_P = PORT_W'(DIVISOR);

  logic [PORT_W-1:0] dvd_q;
  logic [PORT_W-1:0] quot_q;
  logic [RW-1:0]     rem_q;
  logic              run_q;
  logic              done_q;

  logic [MW-1:0]     prod;
  logic [PORT_W-1:0] quot_d;
  logic [PORT_W-1:0] back;
  logic [PORT_W-1:0] diff;

  always_comb begin
    prod   = MW'(dividend_i) * MW'(RECIP);
    quot_d = PORT_W'(prod >> SH);
    back   = quot_q * DIV_P;
    diff   = dvd_q - back;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      dvd_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
    end else begin
      run_q  <= start_i;
      done_q <= run_q;
      if (start_i) begin
        dvd_q  <= dividend_i;
        quot_q <= quot_d;
      end
      if (run_q) begin
        rem_q <= diff[RW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/pna_map.sv @@
// ----------------------------------------------------------------------------
// pna_map
// Bitmap memory of used ports: one write and one registered read per cycle.
// Sweeps every word to zero after reset; outside writes are dropped meanwhile.
// ----------------------------------------------------------------------------
module pna_map #(
  parameter int MAP_WORDS = 2048,
  parameter int WORD_BITS = 32,
  parameter int AW        = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i,
  output logic                 clearing_o
);

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 clearing_q;
  logic [AW-1:0]        clr_addr_q;

  logic                 we;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;

  always_comb begin
    we = clearing_q || wr_en_i;
    wa = clearing_q ? clr_addr_q : wr_addr_i;
    wd = clearing_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

@@ rtl/port_number_allocator.sv @@
// ----------------------------------------------------------------------------
// port_number_allocator
// First-fit port number allocator over a bitmap of used ports: reserve,
// allocate one, allocate a consecutive pair, release.
// ----------------------------------------------------------------------------
// Usage: after reset, busy stays high while the bitmap memory is cleared;
// configuration writes are taken meanwhile. A command is taken when start
// is high and busy is low, and busy then stays high until its result.
// Each command first splits its port (range_low for allocations) into word
// and bit with a reciprocal-multiply divider, then works on the bitmap
// through the memory's one read and one write port. Reserve and release
// read the word and write it back when it changes, or show their result
// straight after the divider when the port fails the range check. An
// allocation reads one more bitmap word for each word scanned past the
// first, and writes the previous word back when a pair straddles two words.
// busy drops with the result, so the next command can be taken at the edge
// that ends it. The result is shown for exactly one cycle with done_o; it
// cannot be held off, so the receiver must take it then.
module port_number_allocator #(
  parameter int MAP_WORDS = 2048,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [pna_pkg::OP_W-1:0]       operation_i,
  input  logic [pna_pkg::PORT_W-1:0]     port_i,
  input  logic                           cfg_we_i,
  input  logic [pna_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pna_pkg::PORT_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic [pna_pkg::PORT_W-1:0]     granted_port_o,
  output logic [pna_pkg::STATUS_W-1:0]   status_o,
  output logic [pna_pkg::COUNT_W-1:0]    used_count_o
);
  import pna_pkg::*;

  localparam int CAP = MAP_WORDS * WORD_BITS;
  localparam int PW  = ($clog2(CAP) + 1 > 17) ? $clog2(CAP) + 1 : 17;
  localparam int WW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW  = $clog2(WORD_BITS);
  localparam logic [PW-1:0] CAP_M1 = PW'(CAP - 1);
  localparam logic [PW-1:0] WB_P   = PW'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE_W  = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] TWO_W  = WORD_BITS'(3);
  localparam logic [WORD_BITS-1:0] MSB_W  = ONE_W << (WORD_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_WRPREV
  } state_e;

  function automatic logic [BW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BW'(i);
      end
    end
    return r;
  endfunction

  state_e               state_q;
  op_e                  op_q;
  logic [PORT_W-1:0]    port_q;
  logic [WW-1:0]        word_q;
  logic [BW-1:0]        bit_q;
  logic [PW-1:0]        base_q;
  logic                 first_q;
  logic                 prev_free_q;
  logic [WORD_BITS-1:0] prev_data_q;
  logic [COUNT_W-1:0]   count_q;
  logic [PORT_W-1:0]    granted_q;
  status_e              status_q;
  logic                 done_q;
  logic [PORT_W-1:0]    range_low_q;
  logic [PORT_W-1:0]    range_high_q;

  logic                 accept;
  logic                 clearing;
  op_e                  op_in;
  logic                 alloc_in;
  logic                 alloc_q;
  logic [PORT_W-1:0]    div_dividend;
  logic                 div_done;
  logic [PORT_W-1:0]    div_quot;
  logic [BW-1:0]        div_rem;
  logic [PORT_W-1:0]    dvd_held;
  logic [PW-1:0]        div_base;
  logic [PW-1:0]        top;
  logic [PW-1:0]        ext_port;
  logic [PW-1:0]        ext_low;

  logic                 rd_en;
  logic [WW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [PW-1:0]        lim;
  logic                 last;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] free;
  logic [WORD_BITS-1:0] pair;
  logic                 straddle;
  logic [BW-1:0]        pick_one;
  logic [BW-1:0]        pick_two;
  logic                 rbit;

  logic                 fin;
  status_e              fin_status;
  logic [PORT_W-1:0]    fin_granted;
  logic [COUNT_W-1:0]   count_d;
  logic                 advance;
  logic                 to_wrprev;

  assign op_in    = op_e'(operation_i);
  assign alloc_in = (op_in == OP_ALLOC_ONE) || (op_in == OP_ALLOC_TWO);
  assign alloc_q  = (op_q == OP_ALLOC_ONE) || (op_q == OP_ALLOC_TWO);
  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE) || clearing;

  assign div_dividend = alloc_in ? range_low_q : port_i;
  assign dvd_held     = alloc_q ? range_low_q : port_q;
  assign div_base     = PW'(dvd_held) - PW'(div_rem);

  assign top      = (PW'(range_high_q) > CAP_M1) ? CAP_M1 : PW'(range_high_q);
  assign ext_port = PW'(port_q);
  assign ext_low  = PW'(range_low_q);

  pna_divmod #(
    .DIVISOR (WORD_BITS)
  ) u_divmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  pna_map #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS),
    .AW        (WW)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clearing_o (clearing)
  );

  // scan window of the current word
  always_comb begin
    lim  = top - base_q;
    last = (lim < WB_P);
    for (int i = 0; i < WORD_BITS; i++) begin
      lo_mask[i] = !first_q || (BW'(i) >= bit_q);
      hi_mask[i] = (PW'(i) <= lim);
    end
    free     = ~rd_data & lo_mask & hi_mask;
    pair     = free & (free >> 1);
    straddle = prev_free_q && free[0];
    pick_one = lowest_set(free);
    pick_two = lowest_set(pair);
    rbit     = rd_data[bit_q];
  end

  // A command reads words and writes back what it changes before it finishes,
  // so memory accesses of two commands never overlap.
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = div_quot[WW-1:0];
    wr_en       = 1'b0;
    wr_addr     = word_q;
    wr_data     = rd_data;
    fin         = 1'b0;
    fin_status  = ST_DONE;
    fin_granted = port_q;
    count_d     = count_q;
    advance     = 1'b0;
    to_wrprev   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
      end
      S_DIV: begin
        if (div_done) begin
          unique case (op_q)
            OP_RESERVE: begin
              if (ext_port < ext_low || ext_port > top) begin
                fin        = 1'b1;
                fin_status = ST_IGNORED;
              end else begin
                rd_en = 1'b1;
              end
            end
            OP_RELEASE: begin
              if (ext_port > CAP_M1) begin
                fin        = 1'b1;
                fin_status = ST_NOT_FOUND;
              end else begin
                rd_en = 1'b1;
              end
            end
            OP_ALLOC_ONE, OP_ALLOC_TWO: begin
              if (ext_low > top) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                rd_en = 1'b1;
              end
            end
          endcase
        end
      end
      S_EVAL: begin
        unique case (op_q)
          OP_RESERVE: begin
            fin = 1'b1;
            if (rbit) begin
              fin_status = ST_IGNORED;
            end else begin
              wr_en   = 1'b1;
              wr_data = rd_data | (ONE_W << bit_q);
              count_d = count_q + COUNT_W'(1);
            end
          end
          OP_RELEASE: begin
            fin = 1'b1;
            if (rbit) begin
              wr_en   = 1'b1;
              wr_data = rd_data & ~(ONE_W << bit_q);
              count_d = count_q - COUNT_W'(1);
            end else begin
              fin_status = ST_NOT_FOUND;
            end
          end
          OP_ALLOC_ONE: begin
            if (|free) begin
              fin         = 1'b1;
              wr_en       = 1'b1;
              wr_data     = rd_data | (ONE_W << pick_one);
              count_d     = count_q + COUNT_W'(1);
              fin_granted = PORT_W'(base_q + PW'(pick_one));
            end else if (last) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              advance = 1'b1;
            end
          end
          OP_ALLOC_TWO: begin
            // a pair that starts on the top bit of the previous word wins
            if (straddle) begin
              wr_en     = 1'b1;
              wr_data   = rd_data | ONE_W;
              count_d   = count_q + COUNT_W'(2);
              to_wrprev = 1'b1;
            end else if (|pair) begin
              fin         = 1'b1;
              wr_en       = 1'b1;
              wr_data     = rd_data | (TWO_W << pick_two);
              count_d     = count_q + COUNT_W'(2);
              fin_granted = PORT_W'(base_q + PW'(pick_two));
            end else if (last) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              advance = 1'b1;
            end
          end
        endcase
        if (advance) begin
          rd_en   = 1'b1;
          rd_addr = word_q + WW'(1);
        end
      end
      S_WRPREV: begin
        fin         = 1'b1;
        wr_en       = 1'b1;
        wr_addr     = word_q - WW'(1);
        wr_data     = prev_data_q | MSB_W;
        fin_granted = PORT_W'(base_q - PW'(1));
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_RESERVE;
      count_q      <= '0;
      done_q       <= 1'b0;
      status_q     <= ST_DONE;
      range_low_q  <= '0;
      range_high_q <= '1;
      first_q      <= 1'b0;
      prev_free_q  <= 1'b0;
    end else begin
      done_q  <= fin;
      count_q <= count_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_RANGE_LOW) begin
          range_low_q <= cfg_wdata_i;
        end else if (cfg_index_i == CFG_RANGE_HIGH) begin
          range_high_q <= cfg_wdata_i;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_in;
            port_q  <= port_i;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            word_q      <= div_quot[WW-1:0];
            bit_q       <= div_rem;
            base_q      <= div_base;
            first_q     <= 1'b1;
            prev_free_q <= 1'b0;
            if (!fin) begin
              state_q <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (advance) begin
            word_q      <= word_q + WW'(1);
            base_q      <= base_q + WB_P;
            first_q     <= 1'b0;
            prev_free_q <= free[WORD_BITS-1];
            prev_data_q <= rd_data;
          end else if (to_wrprev) begin
            state_q <= S_WRPREV;
          end
        end
        S_WRPREV: begin
        end
      endcase
      if (fin) begin
        state_q   <= S_IDLE;
        status_q  <= fin_status;
        granted_q <= fin_granted;
      end
    end
  end

  assign done_o         = done_q;
  assign granted_port_o = granted_q;
  assign status_o       = status_q;
  assign used_count_o   = count_q;

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe lasted more than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("command accepted but block not busy");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_o <= COUNT_W'(65536))
    else $error("used port count out of bounds");
`endif

endmodule
